>>> src/pfu_pkg.sv
// Shared types, constants and codes of the PCM frame unpacker.
// Used by every module under src except pfu_ram; depends on nothing else.
package pfu_pkg;

  // Channel capacity of the frame buffer (1 to 32)
  localparam int unsigned MAX_CHANNELS = 8;
  // Bytes per buffer row; one RAM lane per byte of a row
  localparam int unsigned LANES        = 8;
  localparam int unsigned STORE_BYTES  = MAX_CHANNELS * LANES;
  localparam int unsigned BC_W         = $clog2(STORE_BYTES);
  // Two frame buffers: one filling, one draining
  localparam int unsigned NUM_BANKS    = 2;
  localparam int unsigned RAM_DEPTH    = NUM_BANKS * MAX_CHANNELS;
  localparam int unsigned RAM_AW       = $clog2(RAM_DEPTH);
  // Effective channel count ceilings
  localparam int unsigned MAX_IN       = (MAX_CHANNELS < 15) ? MAX_CHANNELS : 15;
  localparam int unsigned MAX_OUT      = (MAX_CHANNELS < 8) ? MAX_CHANNELS : 8;

  // Float exponent offsets: e - KBASE is minus the right shift of the
  // 53-bit significand that gives value * 2^31
  localparam logic [10:0] F32_KBASE = 11'd148;
  localparam logic [10:0] F64_KBASE = 11'd1044;

  typedef enum logic [1:0] {
    ENC_INT = 2'd0,
    ENC_F32 = 2'd1,
    ENC_F64 = 2'd2,
    ENC_OFS = 2'd3
  } pfu_enc_e;

  typedef enum logic [2:0] {
    CFG_SAMPLE_ENCODING = 3'd0,
    CFG_MSB_FIRST       = 3'd1,
    CFG_SAMPLE_BYTES    = 3'd2,
    CFG_IN_CHANNELS     = 3'd3,
    CFG_OUT_CHANNELS    = 3'd4,
    CFG_FRAME_LIMIT     = 3'd5
  } pfu_cfg_idx_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       restart;
  } pfu_in_t;

  typedef struct packed {
    logic signed [31:0] sample;
    logic [2:0]         out_channel;
    logic               last_of_frame;
    logic               clipped;
  } pfu_out_t;

  // Effective (clamped) configuration
  typedef struct packed {
    pfu_enc_e    enc;
    logic        msb_first;
    logic [3:0]  nbytes;
    logic [3:0]  in_ch;
    logic [3:0]  out_ch;
    logic [31:0] frame_limit;
  } pfu_cfg_t;

  // Head of the frame queue as seen by the back end
  typedef struct packed {
    logic valid;
    logic bank;
  } pfu_job_t;

  typedef struct packed {
    logic              en;
    logic [2:0]        lane;
    logic [RAM_AW-1:0] addr;
    logic [7:0]        data;
  } pfu_wr_t;

  typedef struct packed {
    logic                         re;
    logic [LANES-1:0][RAM_AW-1:0] addr;
  } pfu_rd_t;

  typedef struct packed {
    logic [2:0] chan;
    logic       last;
  } pfu_meta_t;

endpackage

>>> src/pfu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Standalone; used for the byte lanes of the frame buffers.
module pfu_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port; read data holds while re_i is low
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/pfu_queue.sv
// Two-entry queue of completed frames; each entry names a frame buffer bank.
// Depends on pfu_pkg.
module pfu_queue
  import pfu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  logic     pop_i,
  output logic     space_o,
  output logic     wr_bank_o,
  output pfu_job_t job_o
);

  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] cnt_q, cnt_d;

  // Banks fill and drain in strict alternation, so the pointers are the bank ids
  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    cnt_d    = cnt_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign space_o     = (cnt_q != 2'(NUM_BANKS));
  assign wr_bank_o   = wr_ptr_q;
  assign job_o.valid = (cnt_q != 2'd0);
  assign job_o.bank  = rd_ptr_q;

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> cnt_q != 2'(NUM_BANKS))
    else $error("frame queue overflow");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> cnt_q != 2'd0)
    else $error("frame queue underflow");

endmodule

>>> src/pfu_front.sv
// Front end: accepts raw bytes, tracks frame assembly and the frame limit,
// writes bytes into the filling bank. Depends on pfu_pkg.
module pfu_front
  import pfu_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  pfu_in_t  in_data_i,
  input  pfu_cfg_t cfg_i,
  input  logic     space_i,
  input  logic     wr_bank_i,
  output logic     push_o,
  output pfu_wr_t  wr_o
);

  logic [BC_W-1:0] bc_q, bc_d;
  logic [31:0]     fd_q, fd_d;
  logic [BC_W-1:0] bc_eff;
  logic [31:0]     fd_eff;
  logic [BC_W:0]   bc_inc;
  logic [7:0]      frame_len;
  logic            acc;
  logic            active;
  logic            done;

  // A byte is taken only while the filling bank is free
  assign in_ready_o = space_i;
  assign acc        = in_valid_i && space_i;

  // Frame assembly and frame counting
  always_comb begin
    bc_eff    = in_data_i.restart ? '0 : bc_q;
    fd_eff    = in_data_i.restart ? '0 : fd_q;
    active    = fd_eff < cfg_i.frame_limit;
    frame_len = {4'd0, cfg_i.nbytes} * {4'd0, cfg_i.in_ch};
    bc_inc    = {1'b0, bc_eff} + (BC_W+1)'(1);
    done      = 9'(bc_inc) >= 9'(frame_len);

    bc_d       = bc_q;
    fd_d       = fd_q;
    push_o     = 1'b0;
    wr_o.en    = 1'b0;
    wr_o.lane  = bc_eff[2:0];
    wr_o.addr  = (wr_bank_i ? RAM_AW'(MAX_CHANNELS) : '0) + RAM_AW'(bc_eff >> 3);
    wr_o.data  = in_data_i.data_byte;

    if (acc) begin
      bc_d = bc_eff;
      fd_d = fd_eff;
      if (active) begin
        wr_o.en = 1'b1;
        if (done) begin
          bc_d   = '0;
          fd_d   = fd_eff + 32'd1;
          push_o = 1'b1;
        end else begin
          bc_d = bc_inc[BC_W-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bc_q <= '0;
      fd_q <= '0;
    end else begin
      bc_q <= bc_d;
      fd_q <= fd_d;
    end
  end

  a_push_on_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |-> wr_o.en && acc)
    else $error("frame completed without a stored word");

endmodule

>>> src/pfu_back.sv
// Back end: walks the output channels of each queued frame, reads sample bytes
// from the lane RAMs and converts them to Q1.31. Depends on pfu_pkg.
module pfu_back
  import pfu_pkg::*;
(
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  pfu_cfg_t                    cfg_i,
  input  pfu_job_t                    job_i,
  output logic                        pop_o,
  output pfu_rd_t                     rd_o,
  input  logic [LANES-1:0][7:0]       rdata_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output pfu_out_t                    out_data_o
);

  logic       adv;
  logic       issue;
  logic [2:0] ch_q, ch_d;
  logic [3:0] src;
  logic [7:0] pos;
  logic [7:0] row;
  logic       last;

  // Read stage (RAM data register)
  logic       r_v_q;
  pfu_meta_t  r_meta_q;
  logic [2:0] r_rot_q;

  // Classify stage
  logic        c_v_q;
  pfu_meta_t   c_meta_q;
  logic        c_float_q, c_nan_q, c_neg_q, c_big_q, c_zero_q;
  logic [5:0]  c_r_q;
  logic [52:0] c_sig_q;
  logic [31:0] c_int_q;

  // Shift stage
  logic        s_v_q;
  pfu_meta_t   s_meta_q;
  logic        s_float_q, s_nan_q, s_neg_q, s_big_q;
  logic [31:0] s_mag_q;
  logic [31:0] s_int_q;

  // Output register
  logic     out_valid_q;
  pfu_out_t out_q;

  // Whole pipe moves when the output register is free or being taken
  assign adv   = !out_valid_q || out_ready_i;
  assign issue = job_i.valid && adv;

  // Channel sequencer and lane read addresses
  always_comb begin
    src    = (4'(ch_q) < cfg_i.in_ch) ? 4'(ch_q) : cfg_i.in_ch - 4'd1;
    pos    = {4'd0, src} * {4'd0, cfg_i.nbytes};
    row    = pos >> 3;
    last   = (4'(ch_q) == cfg_i.out_ch - 4'd1);
    pop_o  = issue && last;
    ch_d   = ch_q;
    if (issue) begin
      ch_d = last ? 3'd0 : ch_q + 3'd1;
    end
    rd_o.re = adv;
    for (int l = 0; l < LANES; l++) begin
      // lanes below the start offset hold bytes of the next row
      rd_o.addr[l] = (job_i.bank ? RAM_AW'(MAX_CHANNELS) : '0) + RAM_AW'(row)
                     + ((3'(l) < pos[2:0]) ? RAM_AW'(1) : '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q <= 3'd0;
    end else begin
      ch_q <= ch_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r_v_q <= 1'b0;
    end else if (adv) begin
      r_v_q <= issue;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      r_meta_q.chan <= ch_q;
      r_meta_q.last <= last;
      r_rot_q       <= pos[2:0];
    end
  end

  // Classify: rotate lanes into byte order, assemble and split the word
  logic [LANES-1:0][7:0] b;
  logic [63:0]           w;
  logic [31:0]           fbits;
  logic [31:0]           int_val;
  logic [10:0]           e;
  logic [51:0]           mant;
  logic [10:0]           kbase;
  logic                  emax;
  logic                  is_float;
  logic                  sgn;
  logic signed [12:0]    diff;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      b[i] = rdata_i[3'(r_rot_q + 3'(i))];
    end
    for (int i = 0; i < LANES; i++) begin
      w[8*i +: 8] = cfg_i.msb_first ? b[LANES-1-i] : b[i];
    end
    fbits    = cfg_i.msb_first ? w[63:32] : w[31:0];
    int_val  = '0;
    is_float = 1'b0;
    sgn      = 1'b0;
    e        = '0;
    mant     = '0;
    kbase    = F32_KBASE;
    emax     = 1'b0;
    unique case (cfg_i.enc)
      ENC_INT: begin
        if (cfg_i.msb_first) begin
          unique case (cfg_i.nbytes)
            4'd1:    int_val = {w[63:56], 24'd0};
            4'd2:    int_val = {w[63:48], 16'd0};
            4'd3:    int_val = {w[63:40], 8'd0};
            default: int_val = w[63:32];
          endcase
        end else begin
          unique case (cfg_i.nbytes)
            4'd1:    int_val = {w[7:0], 24'd0};
            4'd2:    int_val = {w[15:0], 16'd0};
            4'd3:    int_val = {w[23:0], 8'd0};
            default: int_val = w[31:0];
          endcase
        end
      end
      ENC_OFS: begin
        int_val = {b[0] ^ 8'h80, 24'd0};
      end
      ENC_F32: begin
        is_float = 1'b1;
        sgn      = fbits[31];
        e        = {3'd0, fbits[30:23]};
        mant     = {fbits[22:0], 29'd0};
        kbase    = F32_KBASE;
        emax     = (fbits[30:23] == 8'hFF);
      end
      ENC_F64: begin
        is_float = 1'b1;
        sgn      = w[63];
        e        = w[62:52];
        mant     = w[51:0];
        kbase    = F64_KBASE;
        emax     = (w[62:52] == 11'h7FF);
      end
      default: ;
    endcase
    diff = $signed({2'b00, kbase}) - $signed({2'b00, e});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_v_q <= 1'b0;
    end else if (adv) begin
      c_v_q <= r_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c_meta_q  <= r_meta_q;
      c_float_q <= is_float;
      c_nan_q   <= emax && (mant != '0);
      c_neg_q   <= sgn;
      // at or above 2^32 after scaling: infinity or a shift under 21 bits
      c_big_q   <= emax ? (mant == '0) : ((e != '0) && (diff < 13'sd21));
      c_zero_q  <= (e == '0) || (diff > 13'sd52);
      c_r_q     <= diff[5:0];
      c_sig_q   <= {1'b1, mant};
      c_int_q   <= int_val;
    end
  end

  // Shift: truncate the significand toward zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s_v_q <= 1'b0;
    end else if (adv) begin
      s_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s_meta_q  <= c_meta_q;
      s_float_q <= c_float_q;
      s_nan_q   <= c_nan_q;
      s_neg_q   <= c_neg_q;
      s_big_q   <= c_big_q;
      s_mag_q   <= c_zero_q ? '0 : 32'(c_sig_q >> c_r_q);
      s_int_q   <= c_int_q;
    end
  end

  // Saturate, apply sign, register the result word
  pfu_out_t res;

  always_comb begin
    res.out_channel   = s_meta_q.chan;
    res.last_of_frame = s_meta_q.last;
    res.clipped       = 1'b0;
    res.sample        = s_int_q;
    if (s_float_q) begin
      if (s_nan_q) begin
        res.sample = '0;
      end else if (s_neg_q) begin
        if (s_big_q || (s_mag_q > 32'h8000_0000)) begin
          res.clipped = 1'b1;
          res.sample  = 32'h8000_0000;
        end else begin
          res.sample  = 32'd0 - s_mag_q;
        end
      end else begin
        if (s_big_q || (s_mag_q > 32'h7FFF_FFFF)) begin
          res.clipped = 1'b1;
          res.sample  = 32'h7FFF_FFFF;
        end else begin
          res.sample  = s_mag_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= s_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_clip_saturates: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.clipped |->
      (out_data_o.sample == 32'h7FFF_FFFF) || (out_data_o.sample == 32'h8000_0000))
    else $error("clipped word not at full scale");

  a_pop_needs_job: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> job_i.valid && adv)
    else $error("frame released without a queued frame");

endmodule

>>> src/pcm_frame_unpacker_unit.sv
// PCM frame unpacker top level: configuration registers, front end, frame
// queue, back end and the byte-lane frame buffers. Depends on pfu_pkg.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one raw sample byte
//   per word; restart clears frame assembly and the frame count first.
//   Output channel (out_valid_o/out_ready_i/out_data_o) gives one Q1.31
//   sample word per output channel of each completed frame, in channel order.
//   Configuration port (cfg_valid_i/cfg_ready_o/cfg_index_i/cfg_data_i) is
//   always ready; write it only while no frame results are outstanding.
// Timing:
//   Input takes one byte per cycle while a frame buffer bank is free; two
//   banks let one frame fill while the previous one drains.
//   After the frame's final byte is accepted, its first result passes the queue,
//   the RAM read register, the classify and shift stages and the output register;
//   the remaining channels follow one word per cycle while out_ready_i holds.
// Reset and stalls:
//   Reset loads the default configuration and clears the byte and frame
//   counts and the queue; buffer contents are not cleared.
//   A stalled receiver freezes the whole back-end pipe; once both banks hold
//   undelivered frames, in_ready_o drops until a bank is released.
module pcm_frame_unpacker_unit
  import pfu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  pfu_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output pfu_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  logic [1:0]  enc_q;
  logic        be_q;
  logic [3:0]  sb_q;
  logic [3:0]  ic_q;
  logic [3:0]  oc_q;
  logic [31:0] limit_q;
  pfu_cfg_t    cfg;

  logic     push;
  logic     pop;
  logic     space;
  logic     wr_bank;
  pfu_job_t job;
  pfu_wr_t  wr;
  pfu_rd_t  rd;
  logic [LANES-1:0][7:0] rdata;

  // Configuration registers
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enc_q   <= ENC_INT;
      be_q    <= 1'b0;
      sb_q    <= 4'd2;
      ic_q    <= 4'd2;
      oc_q    <= 4'd2;
      limit_q <= 32'd0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_SAMPLE_ENCODING: enc_q   <= cfg_data_i[1:0];
        CFG_MSB_FIRST:       be_q    <= cfg_data_i[0];
        CFG_SAMPLE_BYTES:    sb_q    <= cfg_data_i[3:0];
        CFG_IN_CHANNELS:     ic_q    <= cfg_data_i[3:0];
        CFG_OUT_CHANNELS:    oc_q    <= cfg_data_i[3:0];
        CFG_FRAME_LIMIT:     limit_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Effective settings: bytes per sample and clamped channel counts
  always_comb begin
    cfg.enc         = pfu_enc_e'(enc_q);
    cfg.msb_first   = be_q;
    cfg.frame_limit = limit_q;
    unique case (cfg.enc)
      ENC_F32: cfg.nbytes = 4'd4;
      ENC_F64: cfg.nbytes = 4'd8;
      ENC_OFS: cfg.nbytes = 4'd1;
      default: begin
        if (sb_q == 4'd0) begin
          cfg.nbytes = 4'd1;
        end else if (sb_q > 4'd4) begin
          cfg.nbytes = 4'd4;
        end else begin
          cfg.nbytes = sb_q;
        end
      end
    endcase
    if (ic_q == 4'd0) begin
      cfg.in_ch = 4'd1;
    end else if (ic_q > 4'(MAX_IN)) begin
      cfg.in_ch = 4'(MAX_IN);
    end else begin
      cfg.in_ch = ic_q;
    end
    if (oc_q == 4'd0) begin
      cfg.out_ch = 4'd1;
    end else if (oc_q > 4'(MAX_OUT)) begin
      cfg.out_ch = 4'(MAX_OUT);
    end else begin
      cfg.out_ch = oc_q;
    end
  end

  pfu_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .cfg_i      (cfg),
    .space_i    (space),
    .wr_bank_i  (wr_bank),
    .push_o     (push),
    .wr_o       (wr)
  );

  pfu_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .pop_i     (pop),
    .space_o   (space),
    .wr_bank_o (wr_bank),
    .job_o     (job)
  );

  // Frame buffers: one RAM per byte lane, both banks stacked in each
  for (genvar l = 0; l < LANES; l++) begin : g_lane
    pfu_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (wr.en && (wr.lane == 3'(l))),
      .waddr_i (wr.addr),
      .wdata_i (wr.data),
      .re_i    (rd.re),
      .raddr_i (rd.addr[l]),
      .rdata_o (rdata[l])
    );
  end

  pfu_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_i       (job),
    .pop_o       (pop),
    .rd_o        (rd),
    .rdata_i     (rdata),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

>>> tb/pfu_frame_checker.sv
// Scoreboard for the PCM frame unpacker: mirrors configuration writes, predicts the
// sample words of every completed frame and compares them with the output channel.
// Depends on pfu_pkg for the word types, encodings and register indexes.
module pfu_frame_checker
  import pfu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  pfu_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  pfu_out_t    out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o,
  output int          bytes_taken_o,
  output int          words_seen_o,
  output int          cfg_writes_o
);

  // Shadow configuration
  pfu_enc_e    cfg_enc;
  logic        cfg_msb_first;
  logic [3:0]  cfg_nbytes;
  logic [3:0]  cfg_in_ch;
  logic [3:0]  cfg_out_ch;
  logic [31:0] cfg_frame_limit;

  // Frame assembly state
  logic [7:0]  held_bytes [STORE_BYTES];
  int unsigned fill;
  logic [31:0] frames_taken;

  pfu_out_t    frame_words_due [$];
  pfu_out_t    head_word;

  function automatic int unsigned sample_width();
    case (cfg_enc)
      ENC_F32: return 4;
      ENC_F64: return 8;
      ENC_OFS: return 1;
      default: return (cfg_nbytes == 0) ? 1 : (cfg_nbytes > 4) ? 4 : cfg_nbytes;
    endcase
  endfunction

  function automatic int unsigned in_channels_eff();
    return (cfg_in_ch == 0) ? 1 : (cfg_in_ch > MAX_CHANNELS) ? MAX_CHANNELS : cfg_in_ch;
  endfunction

  function automatic int unsigned out_channels_eff();
    return (cfg_out_ch == 0) ? 1 : (cfg_out_ch > MAX_OUT) ? MAX_OUT : cfg_out_ch;
  endfunction

  // Assemble n stored bytes into one value, honoring byte order
  function automatic logic [63:0] gather_bytes(input int unsigned pos, input int unsigned n);
    logic [63:0] acc;
    int unsigned k;
    int unsigned i;
    acc = '0;
    for (i = 0; i < n; i++) begin
      k = pos + (cfg_msb_first ? i : (n - 1 - i));
      acc = {acc[55:0], (k < STORE_BYTES) ? held_bytes[k] : 8'h00};
    end
    return acc;
  endfunction

  // IEEE value times 2^31, truncated toward zero, saturated to 32 bits
  function automatic logic [31:0] float_to_q31(input logic [63:0] raw_bits, input logic wide,
                                               output logic clip);
    int unsigned mbits;
    int unsigned ebits;
    int          bias;
    int          sh;
    logic [63:0] mant;
    logic [63:0] sig;
    logic [63:0] mag;
    logic [10:0] expo;
    logic [10:0] emax;
    logic        neg;
    logic        big;
    mbits = wide ? 52 : 23;
    ebits = wide ? 11 : 8;
    bias  = wide ? 1023 : 127;
    mant  = raw_bits & ((64'd1 << mbits) - 64'd1);
    expo  = 11'((raw_bits >> mbits) & ((64'd1 << ebits) - 64'd1));
    neg   = raw_bits[mbits + ebits];
    emax  = 11'((64'd1 << ebits) - 64'd1);
    clip  = 1'b0;
    big   = 1'b0;
    mag   = '0;
    if (expo == emax) begin
      // NaN reads as zero, infinity saturates
      if (mant != 0) return 32'd0;
      big = 1'b1;
    end else begin
      sig = (expo != 0) ? (mant | (64'd1 << mbits)) : mant;
      sh  = ((expo != 0) ? int'(expo) : 1) - bias - int'(mbits) + 31;
      if (sig == 0) begin
        mag = '0;
      end else if (sh >= 0) begin
        if (sh >= 32 || (sig >> (32 - sh)) != 0) big = 1'b1;
        else mag = sig << sh;
      end else begin
        mag = (-sh >= 64) ? 64'd0 : (sig >> (-sh));
        if (mag[63:32] != 0) big = 1'b1;
      end
    end
    if (neg) begin
      // exactly -2^31 still fits
      if (big || mag > 64'h8000_0000) begin
        clip = 1'b1;
        return 32'h8000_0000;
      end
      return 32'd0 - mag[31:0];
    end
    if (big || mag > 64'h7FFF_FFFF) begin
      clip = 1'b1;
      return 32'h7FFF_FFFF;
    end
    return mag[31:0];
  endfunction

  // One accepted byte: store it and queue the words of a completed frame
  task automatic decode_frame_words(input pfu_in_t w);
    int unsigned width;
    int unsigned nin;
    int unsigned nout;
    int unsigned src;
    int unsigned c;
    logic [63:0] raw;
    logic [31:0] value;
    logic        clip;
    pfu_out_t    word;
    if (w.restart) begin
      fill = 0;
      frames_taken = '0;
    end
    // past the frame limit bytes are dropped
    if (frames_taken >= cfg_frame_limit) return;
    width = sample_width();
    nin   = in_channels_eff();
    nout  = out_channels_eff();
    if (fill < STORE_BYTES) held_bytes[fill] = w.data_byte;
    fill++;
    if (fill < width * nin) return;
    fill = 0;
    frames_taken++;
    for (c = 0; c < nout; c++) begin
      // missing channels repeat the last input channel
      src  = (c < nin) ? c : nin - 1;
      raw  = gather_bytes(src * width, width);
      clip = 1'b0;
      case (cfg_enc)
        ENC_F32: value = float_to_q31({32'd0, raw[31:0]}, 1'b0, clip);
        ENC_F64: value = float_to_q31(raw, 1'b1, clip);
        ENC_OFS: value = {raw[7:0] ^ 8'h80, 24'd0};
        default: value = 32'(raw << (32 - 8 * width));
      endcase
      word.sample        = value;
      word.out_channel   = c[2:0];
      word.last_of_frame = (c == nout - 1);
      word.clipped       = clip;
      frame_words_due.push_back(word);
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      fail_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_enc         = ENC_INT;
      cfg_msb_first   = 1'b0;
      cfg_nbytes      = 4'd2;
      cfg_in_ch       = 4'd2;
      cfg_out_ch      = 4'd2;
      cfg_frame_limit = '0;
      fill            = 0;
      frames_taken    = '0;
      frame_words_due.delete();
      fail_count_o    = 0;
      pending_o       = 0;
      bytes_taken_o   = 0;
      words_seen_o    = 0;
      cfg_writes_o    = 0;
    end else begin
      // result words against the oldest prediction
      if (out_valid_i && out_ready_i) begin
        words_seen_o++;
        if (frame_words_due.size() == 0) begin
          $error("sample word with none due: sample %h chan %0d last %b clip %b",
                 out_data_i.sample, out_data_i.out_channel, out_data_i.last_of_frame,
                 out_data_i.clipped);
          fail_count_o++;
        end else begin
          head_word = frame_words_due.pop_front();
          check_field("sample", head_word.sample, out_data_i.sample);
          check_field("out_channel", 32'(head_word.out_channel), 32'(out_data_i.out_channel));
          check_field("last_of_frame", 32'(head_word.last_of_frame),
                      32'(out_data_i.last_of_frame));
          check_field("clipped", 32'(head_word.clipped), 32'(out_data_i.clipped));
        end
      end
      // register writes
      if (cfg_valid_i && cfg_ready_i) begin
        cfg_writes_o++;
        case (pfu_cfg_idx_e'(cfg_index_i))
          CFG_SAMPLE_ENCODING: cfg_enc = pfu_enc_e'(cfg_data_i[1:0]);
          CFG_MSB_FIRST:       cfg_msb_first = cfg_data_i[0];
          CFG_SAMPLE_BYTES:    cfg_nbytes = cfg_data_i[3:0];
          CFG_IN_CHANNELS:     cfg_in_ch = cfg_data_i[3:0];
          CFG_OUT_CHANNELS:    cfg_out_ch = cfg_data_i[3:0];
          CFG_FRAME_LIMIT:     cfg_frame_limit = cfg_data_i;
          default: ;
        endcase
      end
      // input bytes
      if (in_valid_i && in_ready_i) begin
        bytes_taken_o++;
        decode_frame_words(in_data_i);
      end
      pending_o = frame_words_due.size();
    end
  end

endmodule

>>> tb/tb_pcm_frame_unpacker_unit.sv
// Testbench top for pcm_frame_unpacker_unit: drives byte and register traffic with
// random gaps and output stalls; pfu_frame_checker does the prediction and compare.
// Depends on pfu_pkg, pcm_frame_unpacker_unit and pfu_frame_checker.
module tb_pcm_frame_unpacker_unit;
  import pfu_pkg::*;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_ready_o;
  pfu_in_t     in_data_i   = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  pfu_out_t    out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i  = '0;

  int fail_count;
  int pending;
  int bytes_taken;
  int words_seen;
  int cfg_writes;

  // no random gaps on either side while set
  logic        no_idle = 1'b0;
  // effective sample layout of the current setup
  pfu_enc_e    cur_enc = ENC_INT;
  logic        cur_be  = 1'b0;
  int unsigned cur_width = 2;
  int unsigned cur_in    = 2;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  pcm_frame_unpacker_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  pfu_frame_checker u_frame_check (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_data_i     (in_data_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_data_i    (out_data_o),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_i   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .fail_count_o  (fail_count),
    .pending_o     (pending),
    .bytes_taken_o (bytes_taken),
    .words_seen_o  (words_seen),
    .cfg_writes_o  (cfg_writes)
  );

  // One byte word; valid stays high on return so a back-to-back word needs no toggle
  task automatic push_byte(input logic [7:0] b, input logic rs);
    int unsigned gap;
    int          target;
    gap = no_idle ? 0 : $urandom_range(0, 6);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    target = bytes_taken + 1;
    in_valid_i <= 1'b1;
    in_data_i  <= '{data_byte: b, restart: rs};
    do @(negedge clk_i); while (bytes_taken < target);
  endtask

  // n bytes of one sample in the current byte order; restart on the first byte if rs
  task automatic push_sample(input logic [63:0] value, input int unsigned n, input logic rs);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      push_byte(cur_be ? value[8 * (n - 1 - i) +: 8] : value[8 * i +: 8], rs && (i == 0));
    end
  endtask

  // Hold off until every predicted word is out, then cover result-free latency
  task automatic settle();
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_reg(input pfu_cfg_idx_e idx, input logic [31:0] val);
    int target;
    target = cfg_writes + 1;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(negedge clk_i); while (cfg_writes < target);
  endtask

  // Write all six registers; only called after settle
  task automatic apply_setup(input pfu_enc_e enc, input logic be, input logic [3:0] nb,
                             input logic [3:0] inch, input logic [3:0] outch,
                             input logic [31:0] limit);
    write_reg(CFG_SAMPLE_ENCODING, 32'(enc));
    write_reg(CFG_MSB_FIRST, 32'(be));
    write_reg(CFG_SAMPLE_BYTES, 32'(nb));
    write_reg(CFG_IN_CHANNELS, 32'(inch));
    write_reg(CFG_OUT_CHANNELS, 32'(outch));
    write_reg(CFG_FRAME_LIMIT, limit);
    cfg_valid_i <= 1'b0;
    cur_enc = enc;
    cur_be  = be;
    case (enc)
      ENC_F32: cur_width = 4;
      ENC_F64: cur_width = 8;
      ENC_OFS: cur_width = 1;
      default: cur_width = (nb == 0) ? 1 : (nb > 4) ? 4 : nb;
    endcase
    cur_in = (inch == 0) ? 1 : (inch > MAX_CHANNELS) ? MAX_CHANNELS : inch;
  endtask

  // Output side: random stall before each word, ready held until the word is taken
  initial begin
    int unsigned stall;
    int          target;
    wait (rst_ni);
    @(negedge clk_i);
    forever begin
      stall = no_idle ? 0 : $urandom_range(0, 6);
      if (stall != 0) begin
        out_ready_i <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      target = words_seen + 1;
      out_ready_i <= 1'b1;
      do @(negedge clk_i); while (words_seen < target);
    end
  end

  // Run guard
  initial begin
    #3_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int unsigned phase;
    int unsigned random_bytes;
    int unsigned frames;
    int unsigned f;
    int unsigned s;
    int unsigned n;
    int unsigned kind;
    int unsigned pick;
    pfu_enc_e    enc;
    logic        be;
    logic [3:0]  nb;
    logic [3:0]  inch;
    logic [3:0]  outch;
    logic [31:0] limit;
    logic [63:0] value;
    logic        lead_restart;
    logic [7:0]  e8;
    logic [10:0] e11;

    repeat (5) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed: reset limit of zero frames decodes nothing
    push_byte(8'h5A, 1'b1);
    push_byte(8'hA5, 1'b0);
    settle();

    // 16-bit little-endian stereo at both integer extremes
    apply_setup(ENC_INT, 1'b0, 4'd2, 4'd2, 4'd2, 32'hFFFF_FFFF);
    push_byte(8'h00, 1'b1);
    push_byte(8'h80, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h7F, 1'b0);
    settle();

    // float32 big-endian: +1.0 clips, -1.0 does not, NaN, -inf; the
    // sample_bytes setting is ignored and four extra outputs repeat the last channel
    apply_setup(ENC_F32, 1'b1, 4'd15, 4'd4, 4'd8, 32'hFFFF_FFFF);
    push_sample(64'h3F80_0000, 4, 1'b1);
    push_sample(64'hBF80_0000, 4, 1'b0);
    push_sample(64'h7FC0_0001, 4, 1'b0);
    push_sample(64'hFF80_0000, 4, 1'b0);
    settle();

    // offset-binary mono copied to three outputs, frame limit of two, then restart
    apply_setup(ENC_OFS, 1'b0, 4'd0, 4'd1, 4'd3, 32'd2);
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h80, 1'b1);

    // Random phases: one setup each, mostly whole frames of random samples
    phase = 0;
    random_bytes = 0;
    while (random_bytes < 154) begin
      settle();
      enc   = pfu_enc_e'($urandom_range(0, 3));
      be    = 1'($urandom_range(0, 1));
      nb    = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 4));
      inch  = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                          : 4'($urandom_range(1, 3));
      outch = 4'($urandom_range(0, 15));
      pick  = $urandom_range(0, 19);
      limit = (pick == 0) ? $urandom : (pick < 4) ? $urandom_range(1, 3) : 32'hFFFF_FFFF;
      // channel and width extremes early on
      if (phase == 0) begin
        enc = ENC_INT; nb = 4'd15; inch = 4'd15; outch = 4'd0;
      end else if (phase == 1) begin
        enc = ENC_F64; nb = 4'd0; inch = 4'd0; outch = 4'd15;
      end
      apply_setup(enc, be, nb, inch, outch, limit);
      no_idle = (phase % 4 == 3);

      if (phase > 1 && $urandom_range(0, 9) == 0) begin
        // noise: raw bytes, stray restarts, frames left half full
        n = $urandom_range(1, 20);
        repeat (n) push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
      end else begin
        // no leading restart: a held partial frame finishes under the new setup
        lead_restart = ($urandom_range(0, 3) != 0);
        frames = 24 / (cur_width * cur_in);
        if (frames == 0) frames = 1;
        n = frames * cur_width * cur_in;
        for (f = 0; f < frames; f++) begin
          for (s = 0; s < cur_in; s++) begin
            value = {$urandom, $urandom};
            kind  = $urandom_range(0, 15);
            if (cur_enc == ENC_F32) begin
              // infinities and NaNs, zeros and denormals, else near full scale
              e8 = (kind == 0) ? 8'hFF : (kind == 1) ? 8'h00 : 8'($urandom_range(93, 128));
              value = {32'd0, value[31], e8, value[22:0]};
              if (kind < 2 && $urandom_range(0, 1)) value[22:0] = '0;
            end else if (cur_enc == ENC_F64) begin
              e11 = (kind == 0) ? 11'h7FF : (kind == 1) ? 11'h000
                                          : 11'($urandom_range(989, 1024));
              value = {value[63], e11, value[51:0]};
              if (kind < 2 && $urandom_range(0, 1)) value[51:0] = '0;
            end
            push_sample(value, cur_width, lead_restart && f == 0 && s == 0);
          end
        end
      end
      // every sent byte counts toward the run length
      random_bytes += n;
      phase++;
    end

    no_idle = 1'b0;
    settle();
    repeat (12) @(negedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
